// ===== rtl/dthl_pkg.sv =====
// shared types and constants of the depth to height level map
// no dependencies; imported by every module of the block
package dthl_pkg;

    localparam int DEPTH_W  = 16;
    localparam int COORD_W  = 10;
    localparam int ROI_W    = 11;
    localparam int COUNT_W  = 4;
    localparam int REG_IDX_W = 3;
    // level_count is four bits, so no more than this many levels can be asked for
    localparam int COUNT_MAX = 15;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_GROUND_DEPTH = 3'd0,
        REG_LEVEL_STEP   = 3'd1,
        REG_LEVEL_COUNT  = 3'd2,
        REG_ROI_LEFT     = 3'd3,
        REG_ROI_RIGHT    = 3'd4,
        REG_ROI_TOP      = 3'd5,
        REG_ROI_BOTTOM   = 3'd6
    } reg_idx_t;

    localparam logic [DEPTH_W-1:0] GROUND_DEPTH_RST = 16'd4000;
    localparam logic [DEPTH_W-1:0] LEVEL_STEP_RST   = 16'd1666;
    localparam logic [COUNT_W-1:0] LEVEL_COUNT_RST  = 4'd2;
    localparam logic [ROI_W-1:0]   ROI_LEFT_RST     = 11'd0;
    localparam logic [ROI_W-1:0]   ROI_RIGHT_RST    = 11'd1024;
    localparam logic [ROI_W-1:0]   ROI_TOP_RST      = 11'd0;
    localparam logic [ROI_W-1:0]   ROI_BOTTOM_RST   = 11'd1024;

    // pixel word as it travels down the pipeline
    typedef struct packed {
        logic [DEPTH_W-1:0] height;
        logic               in_roi;
    } pix_t;

endpackage

// ===== rtl/dthl_front.sv =====
// first stage: missing depth substitution, height above ground, roi test
// depends on dthl_pkg
module dthl_front #(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic [dthl_pkg::DEPTH_W-1:0]      depth_sample,
    input  logic                              sample_invalid,
    input  logic [dthl_pkg::COORD_W-1:0]      pixel_col,
    input  logic [dthl_pkg::COORD_W-1:0]      pixel_row,
    input  logic [dthl_pkg::DEPTH_W-1:0]      ground_depth,
    input  logic [dthl_pkg::ROI_W-1:0]        roi_left,
    input  logic [dthl_pkg::ROI_W-1:0]        roi_right,
    input  logic [dthl_pkg::ROI_W-1:0]        roi_top,
    input  logic [dthl_pkg::ROI_W-1:0]        roi_bottom,
    output logic                              out_valid,
    output dthl_pkg::pix_t                    out_pix
);
    import dthl_pkg::*;

    localparam int LIM_W = 13;
    localparam logic [LIM_W-1:0] COL_LIM = LIM_W'(MAX_COLS);
    localparam logic [LIM_W-1:0] ROW_LIM = LIM_W'(MAX_ROWS);

    logic               valid_reg;
    pix_t               pix_reg;
    pix_t               pix_next;
    logic [DEPTH_W-1:0] depth_eff;
    logic [ROI_W-1:0]   col_w;
    logic [ROI_W-1:0]   row_w;

    always_comb
    begin
        depth_eff = (sample_invalid || depth_sample == '0) ? ground_depth : depth_sample;
        col_w = {1'b0, pixel_col};
        row_w = {1'b0, pixel_row};
        pix_next.height = (ground_depth > depth_eff) ? (ground_depth - depth_eff) : '0;
        pix_next.in_roi = (col_w >= roi_left) && (col_w < roi_right) &&
                          (row_w >= roi_top) && (row_w < roi_bottom) &&
                          ({3'b000, pixel_col} < COL_LIM) &&
                          ({3'b000, pixel_row} < ROW_LIM);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        pix_reg <= pix_next;
    end

    assign out_valid = valid_reg;
    assign out_pix   = pix_reg;

endmodule

// ===== rtl/dthl_mult.sv =====
// second stage: all level multiples of the step, one constant multiple per lane
// depends on dthl_pkg
module dthl_mult #(
    parameter int NUM = 15,
    parameter int MW  = 20
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  dthl_pkg::pix_t                in_pix,
    input  logic [dthl_pkg::DEPTH_W-1:0]  level_step,
    output logic                          out_valid,
    output dthl_pkg::pix_t                out_pix,
    output logic [NUM:1][MW-1:0]          out_mult
);
    import dthl_pkg::*;

    logic                 valid_reg;
    pix_t                 pix_reg;
    logic [NUM:1][MW-1:0] mult_reg;
    logic [NUM:1][MW-1:0] mult_next;

    always_comb
    begin
        for (int j = 1; j <= NUM; j++)
            mult_next[j] = MW'(level_step) * MW'(j);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        pix_reg  <= in_pix;
        mult_reg <= mult_next;
    end

    assign out_valid = valid_reg;
    assign out_pix   = pix_reg;
    assign out_mult  = mult_reg;

endmodule

// ===== rtl/dthl_quant.sv =====
// third and fourth stages: compare height with each multiple, then pick the
// first multiple not below it or pass it as is, saturate, apply the roi; uses dthl_pkg
module dthl_quant #(
    parameter int NUM = 15,
    parameter int MW  = 20,
    parameter int NW  = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  dthl_pkg::pix_t                in_pix,
    input  logic [NUM:1][MW-1:0]          in_mult,
    input  logic [dthl_pkg::DEPTH_W-1:0]  level_step,
    input  logic [dthl_pkg::COUNT_W-1:0]  level_count,
    output logic                          out_valid,
    output logic [dthl_pkg::DEPTH_W-1:0]  out_height
);
    import dthl_pkg::*;

    // stage 3
    logic                 valid3_reg;
    pix_t                 pix3_reg;
    logic [NUM:1][MW-1:0] mult3_reg;
    logic [NUM:0]         ge_reg;
    logic [NUM:0]         ge_next;

    // stage 4
    logic                 valid4_reg;
    logic [DEPTH_W-1:0]   height_reg;
    logic [DEPTH_W-1:0]   height_next;
    logic [NW-1:0]        n_eff;
    logic                 pass;
    logic [MW-1:0]        pick;
    logic [DEPTH_W-1:0]   pick_sat;

    always_comb
    begin
        // bit 0 stands for zero levels and never matches
        ge_next[0] = 1'b0;
        for (int j = 1; j <= NUM; j++)
            ge_next[j] = in_mult[j] >= MW'(in_pix.height);
    end

    always_comb
    begin
        n_eff = (level_count > COUNT_W'(NUM)) ? NW'(NUM) : NW'(level_count);
        // heights above the top level, tiny heights and a zero step pass unchanged
        pass = (level_step == '0) || (pix3_reg.height <= DEPTH_W'(1)) || !ge_reg[n_eff];
        // ge is a thermometer code, so its lowest set bit marks the round-up multiple
        pick = '0;
        for (int j = 1; j <= NUM; j++)
            if (ge_reg[j] && !ge_reg[j-1])
                pick = pick | mult3_reg[j];
        pick_sat = (pick[MW-1:DEPTH_W] != '0) ? '1 : pick[DEPTH_W-1:0];
        if (!pix3_reg.in_roi)
            height_next = '0;
        else if (pass)
            height_next = pix3_reg.height;
        else
            height_next = pick_sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid3_reg <= 1'b0;
            valid4_reg <= 1'b0;
        end
        else
        begin
            valid3_reg <= in_valid;
            valid4_reg <= valid3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pix3_reg   <= in_pix;
        mult3_reg  <= in_mult;
        ge_reg     <= ge_next;
        height_reg <= height_next;
    end

    assign out_valid  = valid4_reg;
    assign out_height = height_reg;

endmodule

// ===== rtl/depth_to_height_level_map.sv =====
// depth to height level map: converts depth pixels to quantized height levels
// Usage:
//   Input: raise start with depth_sample, sample_invalid, pixel_col and
//   pixel_row; the word is taken at any clock edge where start is high and
//   busy is low. busy stays low, so one pixel can enter on every clock.
//   Output: done is high for exactly one cycle with height_level. The
//   receiver cannot stall; one result leaves per pixel, in input order.
//   Order: done rises when the accepted pixel has reached the select
//   register; the receiver takes the result while done is high.
//   Throughput: one pixel per clock, set by the four register stages
//   (front end, step multiples, compares, select) which all move every cycle.
//   Configuration: cfg_valid/cfg_ready write channel, cfg_index picks the
//   register (ground depth, step, level count, roi left/right/top/bottom),
//   cfg_data carries the value; cfg_ready is always high. Write only while
//   no pixel is in flight. Unknown indexes are ignored.
//   Reset: rst_n clears the pipeline valid bits and loads the default
//   register values; nothing is pending afterwards.
// depends on dthl_pkg, dthl_front, dthl_mult, dthl_quant
module depth_to_height_level_map #(
    parameter int MAX_LEVELS = 15,
    parameter int MAX_COLS   = 1024,
    parameter int MAX_ROWS   = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [dthl_pkg::DEPTH_W-1:0]      depth_sample,
    input  logic                              sample_invalid,
    input  logic [dthl_pkg::COORD_W-1:0]      pixel_col,
    input  logic [dthl_pkg::COORD_W-1:0]      pixel_row,
    output logic                              done,
    output logic [dthl_pkg::DEPTH_W-1:0]      height_level,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dthl_pkg::REG_IDX_W-1:0]    cfg_index,
    input  logic [dthl_pkg::DEPTH_W-1:0]      cfg_data
);
    import dthl_pkg::*;

    localparam int NUM = (MAX_LEVELS < COUNT_MAX) ? MAX_LEVELS : COUNT_MAX;
    localparam int NW  = $clog2(NUM + 1);
    localparam int MW  = DEPTH_W + NW;

    logic [DEPTH_W-1:0] ground_depth_reg;
    logic [DEPTH_W-1:0] level_step_reg;
    logic [COUNT_W-1:0] level_count_reg;
    logic [ROI_W-1:0]   roi_left_reg;
    logic [ROI_W-1:0]   roi_right_reg;
    logic [ROI_W-1:0]   roi_top_reg;
    logic [ROI_W-1:0]   roi_bottom_reg;

    logic                 accept;
    logic                 v1;
    pix_t                 pix1;
    logic                 v2;
    pix_t                 pix2;
    logic [NUM:1][MW-1:0] mult2;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ground_depth_reg <= GROUND_DEPTH_RST;
            level_step_reg   <= LEVEL_STEP_RST;
            level_count_reg  <= LEVEL_COUNT_RST;
            roi_left_reg     <= ROI_LEFT_RST;
            roi_right_reg    <= ROI_RIGHT_RST;
            roi_top_reg      <= ROI_TOP_RST;
            roi_bottom_reg   <= ROI_BOTTOM_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_GROUND_DEPTH: ground_depth_reg <= cfg_data;
                REG_LEVEL_STEP:   level_step_reg   <= cfg_data;
                REG_LEVEL_COUNT:  level_count_reg  <= cfg_data[COUNT_W-1:0];
                REG_ROI_LEFT:     roi_left_reg     <= cfg_data[ROI_W-1:0];
                REG_ROI_RIGHT:    roi_right_reg    <= cfg_data[ROI_W-1:0];
                REG_ROI_TOP:      roi_top_reg      <= cfg_data[ROI_W-1:0];
                REG_ROI_BOTTOM:   roi_bottom_reg   <= cfg_data[ROI_W-1:0];
                default: ;
            endcase
        end
    end

    dthl_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (accept),
        .depth_sample   (depth_sample),
        .sample_invalid (sample_invalid),
        .pixel_col      (pixel_col),
        .pixel_row      (pixel_row),
        .ground_depth   (ground_depth_reg),
        .roi_left       (roi_left_reg),
        .roi_right      (roi_right_reg),
        .roi_top        (roi_top_reg),
        .roi_bottom     (roi_bottom_reg),
        .out_valid      (v1),
        .out_pix        (pix1)
    );

    dthl_mult #(
        .NUM (NUM),
        .MW  (MW)
    ) u_mult (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (v1),
        .in_pix     (pix1),
        .level_step (level_step_reg),
        .out_valid  (v2),
        .out_pix    (pix2),
        .out_mult   (mult2)
    );

    dthl_quant #(
        .NUM (NUM),
        .MW  (MW),
        .NW  (NW)
    ) u_quant (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (v2),
        .in_pix      (pix2),
        .in_mult     (mult2),
        .level_step  (level_step_reg),
        .level_count (level_count_reg),
        .out_valid   (done),
        .out_height  (height_level)
    );

endmodule
